FILE: hdl/rcpc_pkg.sv
package rcpc_pkg;

  // Capture channel codes
  typedef enum logic [1:0] {
    CH_ROLL     = 2'd0,
    CH_PITCH    = 2'd1,
    CH_THROTTLE = 2'd2,
    CH_YAW      = 2'd3
  } chan_e;

  // Field widths
  localparam int unsigned TimeW = 16;
  localparam int unsigned CtrlW = 14;
  localparam int unsigned CalcW = 18;  // holds 1550 - 65535 with sign

  typedef logic signed [CalcW-1:0] calc_t;
  typedef logic signed [CtrlW-1:0] ctrl_t;

  // Completed pulse, between the capture stage and the mapping stage
  typedef struct packed {
    chan_e            ch;
    logic [TimeW-1:0] width;
  } pulse_t;

  // Stick mapping constants (timer ticks)
  localparam calc_t CenterLo     = 18'sd1450;
  localparam calc_t CenterHi     = 18'sd1550;
  localparam calc_t RollDbLo     = 18'sd1480;
  localparam calc_t RollDbHi     = 18'sd1520;
  localparam calc_t ThrOffset    = 18'sd1100;
  localparam calc_t ThrFloor     = 18'sd5;
  localparam calc_t ThrMax       = 18'sd1000;
  localparam calc_t YawLimit     = 18'sd200;

  // Map a pulse width to the channel's stick command.
  // Roll/pitch: gain 50/400 is a divide by 8; yaw: 200/400 is a divide by 2.
  // Both truncate toward zero.
  function automatic ctrl_t map_stick(chan_e ch, logic [TimeW-1:0] width);
    calc_t w;
    calc_t lo_thr;
    calc_t hi_thr;
    calc_t d;
    calc_t q8;
    calc_t q2;
    calc_t t;
    calc_t v;
    w = calc_t'({{(CalcW-TimeW){1'b0}}, width});
    lo_thr = (ch == CH_ROLL) ? RollDbLo : CenterLo;
    hi_thr = (ch == CH_ROLL) ? RollDbHi : CenterHi;
    // Deadband around center
    if (w <= lo_thr) begin
      d = CenterLo - w;
    end else if (w >= hi_thr) begin
      d = CenterHi - w;
    end else begin
      d = '0;
    end
    q8 = (d < 0) ? ((d + 18'sd7) >>> 3) : (d >>> 3);
    q2 = (d < 0) ? ((d + 18'sd1) >>> 1) : (d >>> 1);
    t  = w - ThrOffset;
    unique case (ch)
      CH_ROLL, CH_PITCH: begin
        v = q8;
      end
      CH_THROTTLE: begin
        if (t <= ThrFloor) begin
          v = '0;
        end else if (t >= ThrMax) begin
          v = ThrMax;
        end else begin
          v = t;
        end
      end
      CH_YAW: begin
        if (q2 >= YawLimit) begin
          v = YawLimit;
        end else if (q2 <= -YawLimit) begin
          v = -YawLimit;
        end else begin
          v = q2;
        end
      end
      default: begin
        v = '0;
      end
    endcase
    return v[CtrlW-1:0];
  endfunction

endpackage

FILE: hdl/rc_pulse_capture_stick_map_core.sv
// Four-channel RC pulse width capture with stick mapping.
// Input stream (s_axis): one word per timer capture event, holding the channel
// (0 roll, 1 pitch, 2 throttle, 3 yaw) and the 16-bit timer value at the edge.
// Events on a channel alternate rising/falling, rising first after reset.
// A rising edge only stores its time and gives no output word. A falling edge
// gives one output word (m_axis): channel, high time modulo 65536 and the
// mapped stick command (14-bit two's complement).
// A falling-edge event passes through the capture register, which loads at the
// accepting edge, and then the mapping register, which loads when m_axis can take it.
// Throughput: one event per cycle while m_axis is not stalled; the capture stage
// subtracts, the mapping stage compares and scales by shifts, each between two registers.
// Reset: all channels expect a rising edge, stored rise times are zero, and
// both pipeline registers are empty.
// Stall: while m_axis_tready is low the output word holds; the capture register
// still fills, and s_axis_tready drops only when both registers are full.
module rc_pulse_capture_stick_map_core
  import rcpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [1:0] channel, [17:2] capture_time, [23:18] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [1:0] out_channel, [17:2] pulse_width,
                                      // [31:18] control_value
);

  // Per-channel edge phase and rise time
  logic [3:0]       awaiting_fall_q, awaiting_fall_d;
  logic [TimeW-1:0] rise_time_q [4];

  // Pipeline registers
  logic   s1_valid_q, s1_valid_d;
  pulse_t s1_q;
  logic   m_valid_q, m_valid_d;
  logic [31:0] m_data_q;

  // Input decode
  chan_e            in_ch;
  logic [TimeW-1:0] in_time;
  logic             s_accept;
  logic             s1_ready;
  logic             is_fall;
  pulse_t           s1_d;
  ctrl_t            ctrl;

  assign in_ch   = chan_e'(s_axis_tdata[1:0]);
  assign in_time = s_axis_tdata[17:2];

  // Pipeline flow control
  assign s1_ready      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_ready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign is_fall       = awaiting_fall_q[in_ch];

  // Capture stage: width as modular difference
  always_comb begin
    s1_d.ch    = in_ch;
    s1_d.width = in_time - rise_time_q[in_ch];
    awaiting_fall_d = awaiting_fall_q;
    if (s_accept) begin
      awaiting_fall_d[in_ch] = !is_fall;
    end
    s1_valid_d = s1_valid_q;
    if (s_accept) begin
      s1_valid_d = is_fall;
    end else if (s1_ready) begin
      s1_valid_d = 1'b0;
    end
  end

  // Mapping stage
  assign ctrl = map_stick(s1_q.ch, s1_q.width);

  always_comb begin
    m_valid_d = m_valid_q;
    if (s1_ready) begin
      m_valid_d = s1_valid_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_fall_q <= '0;
      s1_valid_q      <= 1'b0;
      m_valid_q       <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        rise_time_q[i] <= '0;
      end
    end else begin
      awaiting_fall_q <= awaiting_fall_d;
      s1_valid_q      <= s1_valid_d;
      m_valid_q       <= m_valid_d;
      if (s_accept && !is_fall) begin
        rise_time_q[in_ch] <= in_time;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_q <= s1_d;
    end
    if (s1_ready && s1_valid_q) begin
      m_data_q <= {ctrl, s1_q.width, 2'(s1_q.ch)};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
  // Rising edges never produce a pulse in the capture register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && !is_fall |=> !s1_valid_q)
    else $error("rising edge produced a pulse");

  // Input stalls only with both registers full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid_q && m_valid_q)
    else $error("input stalled with free pipeline space");

  // Throttle command stays within 0..1000
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (m_data_q[1:0] == 2'(CH_THROTTLE)) |->
      !m_data_q[31] && ($unsigned(m_data_q[31:18]) <= 14'd1000))
    else $error("throttle command out of range");

  // Yaw command stays within -200..200
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (m_data_q[1:0] == 2'(CH_YAW)) |->
      ($signed(m_data_q[31:18]) <= 14'sd200) && ($signed(m_data_q[31:18]) >= -14'sd200))
    else $error("yaw command out of range");
`endif

endmodule

FILE: test/tb_top.sv
module tb_top;
  import rcpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Stick mapping constants, timer ticks
  localparam int MidLo       = 1450;
  localparam int MidHi       = 1550;
  localparam int RollBandLo  = 1480;
  localparam int RollBandHi  = 1520;
  localparam int ThrBase     = 1100;
  localparam int ThrDead     = 5;
  localparam int ThrTop      = 1000;
  localparam int YawClamp    = 200;
  localparam int ScaleDiv    = 400;
  localparam int GainRp      = 50;
  localparam int GainYaw     = 200;

  localparam int RandomEvents = 2000;
  localparam int StallLimit   = 1000;
  localparam int DrainCycles  = 10;

  // Widths the random part likes to land near
  localparam int EdgePts [6] = '{1450, 1480, 1520, 1550, 1105, 2100};

  typedef struct {
    chan_e            ch;
    logic [TimeW-1:0] width;
    ctrl_t            ctrl;
  } pulse_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [1:0] channel, [17:2] capture_time, [23:18] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [1:0] out_channel, [17:2] pulse_width,
                               // [31:18] control_value

  // Predictor state: edge phase and stored rise stamp per channel
  logic             phase_fall [4];
  logic [TimeW-1:0] rise_stamp [4];
  pulse_word_t      pending_pulses [$];

  int  err_count;
  int  events_sent;
  int  pulses_checked;
  int  stall_cycles;
  bit  no_idle;

  rc_pulse_capture_stick_map_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Deadband then linear scale, truncating toward zero
  function automatic int deadband_scale(int w, int lo, int hi, int gain);
    if (w <= lo) begin
      return (MidLo - w) * gain / ScaleDiv;
    end else if (w >= hi) begin
      return (MidHi - w) * gain / ScaleDiv;
    end
    return 0;
  endfunction

  function automatic ctrl_t compute_stick_cmd(chan_e ch, logic [TimeW-1:0] width);
    int w;
    int v;
    w = int'(width);
    case (ch)
      CH_ROLL:  v = deadband_scale(w, RollBandLo, RollBandHi, GainRp);
      CH_PITCH: v = deadband_scale(w, MidLo, MidHi, GainRp);
      CH_THROTTLE: begin
        v = w - ThrBase;
        if (v <= ThrDead) begin
          v = 0;
        end else if (v >= ThrTop) begin
          v = ThrTop;
        end
      end
      default: begin
        v = deadband_scale(w, MidLo, MidHi, GainYaw);
        if (v >= YawClamp) begin
          v = YawClamp;
        end else if (v <= -YawClamp) begin
          v = -YawClamp;
        end
      end
    endcase
    return ctrl_t'(v);
  endfunction

  // Advance the channel model by one accepted capture event
  function automatic void capture_predict(chan_e ch, logic [TimeW-1:0] stamp);
    pulse_word_t pw;
    events_sent++;
    if (!phase_fall[ch]) begin
      rise_stamp[ch] = stamp;
      phase_fall[ch] = 1'b1;
    end else begin
      phase_fall[ch] = 1'b0;
      pw.ch    = ch;
      pw.width = stamp - rise_stamp[ch];
      pw.ctrl  = compute_stick_cmd(ch, pw.width);
      pending_pulses.push_back(pw);
    end
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  // Random 16-bit timer value
  function automatic logic [TimeW-1:0] rand_stamp();
    return TimeW'($urandom_range(0, 65535));
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // Send one capture word, waiting out the ready handshake
  task automatic send_event(chan_e ch, logic [TimeW-1:0] stamp);
    int   gap;
    logic ok;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, stamp, ch};
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    capture_predict(ch, stamp);
  endtask

  task automatic send_pulse(chan_e ch, logic [TimeW-1:0] rise, logic [TimeW-1:0] width);
    send_event(ch, rise);
    send_event(ch, rise + width);
  endtask

  // Timer extremes, wrap and a zero-width pulse
  task automatic test_field_extremes();
    send_event(CH_ROLL, 16'h0000);
    send_event(CH_ROLL, 16'hFFFF);
    send_event(CH_PITCH, 16'hFFFF);
    send_event(CH_PITCH, 16'h0000);
    send_pulse(CH_THROTTLE, 16'd64000, 16'd3076);
    send_pulse(CH_YAW, 16'd1234, 16'd0);
  endtask

  // Deadband and clamp boundaries, with channels interleaved at the end
  task automatic test_map_boundaries();
    send_pulse(CH_ROLL, rand_stamp(), 16'd1480);
    send_pulse(CH_ROLL, rand_stamp(), 16'd1520);
    send_pulse(CH_PITCH, rand_stamp(), 16'd1451);
    send_pulse(CH_THROTTLE, rand_stamp(), 16'd1105);
    send_pulse(CH_THROTTLE, rand_stamp(), 16'd1106);
    send_pulse(CH_THROTTLE, rand_stamp(), 16'd2100);
    send_event(CH_YAW, 16'd100);
    send_event(CH_PITCH, 16'd200);
    send_event(CH_YAW, 16'd100 + 16'd1549);
    send_event(CH_PITCH, 16'd200 + 16'd1950);
  endtask

  function automatic logic [TimeW-1:0] pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return TimeW'($urandom_range(900, 2200));
    end else if (r < 80) begin
      return TimeW'(EdgePts[$urandom_range(0, 5)] + int'($urandom_range(0, 6)) - 3);
    end
    return rand_stamp();
  endfunction

  // Mostly well-formed rise/fall pairs spread over channels, some stray edges
  task automatic test_random_pulses();
    chan_e ch;
    for (int i = 0; i < RandomEvents; i++) begin
      if (i % 200 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      ch = chan_e'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0 || !phase_fall[ch]) begin
        send_event(ch, rand_stamp());
      end else begin
        send_event(ch, rise_stamp[ch] + pick_width());
      end
    end
    no_idle = 1'b0;
  endtask

  // Output side: random stall before each word
  initial begin
    int   n;
    logic ok;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      n = draw_gap();
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
        @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        ok = m_axis_tvalid;
        if (!ok) @(posedge clk_i);
      end while (!ok);
    end
  end

  // Result checker: inputs only move at rising edges, so sample midway
  always @(negedge clk_i) begin
    pulse_word_t pw;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pulses.size() == 0) begin
        report_mismatch("unexpected word", int'(m_axis_tdata[1:0]), -1);
      end else begin
        pw = pending_pulses.pop_front();
        pulses_checked++;
        if (m_axis_tdata[1:0] != pw.ch) begin
          report_mismatch("out_channel", int'(m_axis_tdata[1:0]), int'(pw.ch));
        end
        if (m_axis_tdata[17:2] != pw.width) begin
          report_mismatch("pulse_width", int'(m_axis_tdata[17:2]), int'(pw.width));
        end
        if (m_axis_tdata[31:18] != pw.ctrl) begin
          report_mismatch("control_value", int'($signed(m_axis_tdata[31:18])),
                          int'(pw.ctrl));
        end
      end
    end
  end

  // Watchdog on handshake progress
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no word moved for %0d cycles", StallLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    for (int c = 0; c < 4; c++) begin
      phase_fall[c] = 1'b0;
      rise_stamp[c] = '0;
    end
    err_count      = 0;
    events_sent    = 0;
    pulses_checked = 0;
    stall_cycles   = 0;
    no_idle        = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_map_boundaries();
    test_random_pulses();
    s_axis_tvalid <= 1'b0;

    // Drain the expected words, then keep watching for any stray word
    while (pending_pulses.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d capture events on all four channels, incl. timer wrap and edges",
             events_sent);
    $display("Checked %0d pulse words under random input gaps and output stalls",
             pulses_checked);
    if (err_count == 0 && pending_pulses.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
